>>> src/cfd_pkg.sv
// Shared types and constants for the COBS frame decoder.
`default_nettype none
package cfd_pkg;

    localparam int MAX_FRAME_BYTES = 4096;
    localparam int LEN_W           = 13;
    localparam int LEN_MAX         = (1 << LEN_W) - 1;
    localparam int LEN_CAP_INT     = (MAX_FRAME_BYTES > LEN_MAX) ? LEN_MAX : MAX_FRAME_BYTES;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_CAP_INT[LEN_W-1:0];

    localparam logic [7:0] FULL_CODE = 8'hFF;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One queued operation: a first result and an optional trailing delimiter.
    typedef struct packed {
        logic [7:0]       byte_data;
        logic             byte_valid;
        logic             last;
        logic             err;
        logic [LEN_W-1:0] len;
        logic             add_delim;
    } cfd_entry_t;

endpackage : cfd_pkg
`default_nettype wire

>>> src/cfd_front.sv
// Front end: tracks block state per encoded byte and classifies it into queue entries.
`default_nettype none
module cfd_front
    import cfd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] enc_byte,
    input  wire logic       frame_end,
    input  wire logic [7:0] delim,
    output cfd_entry_t      push_entry,
    output logic            push_req
);

    logic [7:0]       bytes_left_reg, bytes_left_next;
    logic             full_reg, full_next;
    logic [LEN_W-1:0] count_reg, count_next;

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] c,
                                                input logic [1:0] inc);
        logic [LEN_W:0] s;
        s = {1'b0, c} + {{(LEN_W-1){1'b0}}, inc};
        return (s > {1'b0, LEN_CAP}) ? LEN_CAP : s[LEN_W-1:0];
    endfunction

    logic [7:0]       code;
    logic [7:0]       bl_dec;
    logic [LEN_W-1:0] cnt1;
    logic             err;

    always_comb begin
        code            = (enc_byte == 8'd0) ? 8'd1 : enc_byte;
        bl_dec          = bytes_left_reg - 8'd1;
        cnt1            = sat_add(count_reg, 2'd1);
        err             = 1'b0;
        bytes_left_next = bytes_left_reg;
        full_next       = full_reg;
        count_next      = count_reg;
        push_req        = 1'b0;
        push_entry      = '0;
        if (bytes_left_reg == 8'd0) begin
            // code byte
            err = (code != 8'd1);
            if (frame_end) begin
                push_req              = 1'b1;
                push_entry.last       = 1'b1;
                push_entry.err        = err;
                push_entry.len        = err ? '0 : count_reg;
                bytes_left_next       = 8'd0;
                full_next             = 1'b0;
                count_next            = '0;
            end else if (code == 8'd1) begin
                push_req              = 1'b1;
                push_entry.byte_data  = delim;
                push_entry.byte_valid = 1'b1;
                bytes_left_next       = 8'd0;
                full_next             = 1'b0;
                count_next            = cnt1;
            end else begin
                bytes_left_next       = code - 8'd1;
                full_next             = (code == FULL_CODE);
            end
        end else begin
            // data byte
            push_req              = 1'b1;
            push_entry.byte_data  = enc_byte;
            push_entry.byte_valid = 1'b1;
            if (frame_end) begin
                err                   = (bl_dec != 8'd0);
                push_entry.last       = 1'b1;
                push_entry.err        = err;
                push_entry.len        = err ? '0 : cnt1;
                bytes_left_next       = 8'd0;
                full_next             = 1'b0;
                count_next            = '0;
            end else begin
                push_entry.add_delim  = (bl_dec == 8'd0) && !full_reg;
                bytes_left_next       = bl_dec;
                count_next            = push_entry.add_delim ? sat_add(count_reg, 2'd2) : cnt1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= 8'd0;
            full_reg       <= 1'b0;
            count_reg      <= '0;
        end else if (accept) begin
            bytes_left_reg <= bytes_left_next;
            full_reg       <= full_next;
            count_reg      <= count_next;
        end
    end

endmodule : cfd_front
`default_nettype wire

>>> src/cfd_queue.sv
// Small FIFO of classified entries between front and back ends.
`default_nettype none
module cfd_queue
    import cfd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire cfd_entry_t push_entry,
    input  wire logic       pop,
    output cfd_entry_t      head,
    output logic            empty,
    output logic            full
);

    cfd_entry_t     slots [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QAW+1)'(QDEPTH));
    assign head  = slots[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule : cfd_queue
`default_nettype wire

>>> src/cfd_back.sv
// Back end: drains queue entries into the output register, one result per beat.
`default_nettype none
module cfd_back
    import cfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfd_entry_t  head,
    input  wire logic        empty,
    output logic             pop,
    input  wire logic [7:0]  delim,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic             m_tlast,
    output logic [1:0]       m_tuser
);

    logic             valid_reg;
    logic             pend_reg;
    logic [7:0]       byte_reg;
    logic             bvalid_reg;
    logic             last_reg;
    logic             err_reg;
    logic [LEN_W-1:0] len_reg;
    logic             load;

    assign load = !valid_reg || m_tready;
    assign pop  = load && !pend_reg && !empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else if (load) begin
            if (pend_reg) begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end else begin
                valid_reg <= !empty;
                pend_reg  <= !empty && head.add_delim;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (pend_reg) begin
                byte_reg   <= delim;
                bvalid_reg <= 1'b1;
                last_reg   <= 1'b0;
                err_reg    <= 1'b0;
                len_reg    <= '0;
            end else begin
                byte_reg   <= head.byte_data;
                bvalid_reg <= head.byte_valid;
                last_reg   <= head.last;
                err_reg    <= head.err;
                len_reg    <= head.len;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(24-8-LEN_W){1'b0}}, len_reg, byte_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = {err_reg, bvalid_reg};

endmodule : cfd_back
`default_nettype wire

>>> src/cobs_frame_decoder.sv
// Top level of the COBS frame decoder: front end, entry queue, back end, delimiter register.
//
//  port group   dir  beat contents (low bit first)
//  s_*          in   tdata: enc_byte[7:0]; tlast: frame_end
//  m_*          out  tdata: out_byte[7:0], decoded_length[20:8], zero pad;
//                    tuser: byte_valid, frame_error; tlast: last_of_frame
//  cfg_*        in   cfg_wr_data: delimiter byte, written when cfg_wr_en is high
//
// One encoded byte is taken per cycle while the four-entry queue has room.
// A data byte that closes a short block yields two results, the byte and then
// a delimiter, one after the other in the output register; every other byte yields at most one.
// An input beat reaches the output through the queue and then the output register.
// aresetn (synchronous) clears block state, queue and output valid; delimiter resets to zero.
// A stalled m_tready backs up the queue and then drops s_tready.
`default_nettype none
module cobs_frame_decoder
    import cfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // encoded input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // enc_byte[7:0]
    input  wire logic        s_tlast,
    // decoded output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // out_byte[7:0], decoded_length[20:8]
    output logic             m_tlast,
    output logic [1:0]       m_tuser,    // byte_valid[0], frame_error[1]
    // delimiter register
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data
);

    logic [7:0]  delim_reg;
    logic        accept;
    logic        push_req;
    cfd_entry_t  push_entry;
    cfd_entry_t  head;
    logic        q_empty;
    logic        q_full;
    logic        pop;

    // Hold the delimiter; the user must write it only while the decoder is idle (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= 8'd0;
        end else if (cfg_wr_en) begin
            delim_reg <= cfg_wr_data;
        end
    end

    // Accept whenever the queue has a free slot.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    cfd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .enc_byte   (s_tdata),
        .frame_end  (s_tlast),
        .delim      (delim_reg),
        .push_entry (push_entry),
        .push_req   (push_req)
    );

    // Push only bytes that produce a result; bare code bytes drop here.
    cfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept && push_req),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    cfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .delim    (delim_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule : cobs_frame_decoder
`default_nettype wire

>>> src/cfd_checker.sv
// Port-level checks for the COBS frame decoder, bound to the top level.
`default_nettype none
module cfd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [1:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata[20:8] == 13'd0))
        else $error("frame error outside final beat or with nonzero length");

    a_len_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[20:8] == 13'd0))
        else $error("length on a beat that is not final");

    a_bare: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[7:0] == 8'd0))
        else $error("bare marker not final or carries a byte");

endmodule : cfd_checker

bind cobs_frame_decoder cfd_checker u_cfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
